// ----- sv/dscd_pkg.sv -----
`default_nettype none
package dscd_pkg;

  localparam int unsigned DATE_LEN   = 10;
  localparam int unsigned POS_SAT    = 11;
  localparam int unsigned SEP_POS_A  = 2;
  localparam int unsigned SEP_POS_B  = 5;
  localparam int unsigned NUM_DIGITS = 8;
  localparam int unsigned MONTHS     = 12;
  localparam int unsigned SPAN_W     = 22;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned PART_W     = 12;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_DAY    = 3'd2,
    ST_MONTH  = 3'd3,
    ST_YEAR   = 3'd4
  } status_t;

  typedef logic [3:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] digits_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        date_status;
    logic              is_departure;
    logic              span_valid;
    logic [SPAN_W-1:0] span_days;
  } out_word_t;

  // Finished string, digits in DD MM YYYY order
  typedef struct packed {
    logic    fmt_err;
    logic    dep;
    digits_t dig;
  } front_out_t;

  typedef struct packed {
    status_t           status;
    logic              dep;
    logic [YEAR_W-1:0] ys;
    logic [6:0]        cent;
    logic [3:0]        mp;
    logic [4:0]        day;
  } check_out_t;

  typedef struct packed {
    status_t           status;
    logic              dep;
    logic [SPAN_W-1:0] dn;
  } daynum_out_t;

  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the shifted month (March is month zero)
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] off;
    unique case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage
`default_nettype wire

// ----- sv/date_string_check_and_day_span_top.sv -----
// Date string checker and day span counter. Feed the characters of two date
// strings (DD?MM?YYYY) one word per cycle, end_of_string on the last one;
// strings alternate arrival, departure, arrival, ... For each string end one
// result word comes out with the date status (format, day, month, year error
// or ok) and, after a departure date with both dates valid, the day count
// from arrival to departure (zero if departure is not later). A new character
// is taken every cycle while the output is not stalled; a result word passes
// through five register stages (character capture at the edge that takes its
// final character, then date check, year scaling, day number sum, span and
// output). Backpressure on the output stalls the whole pipeline at once.
`default_nettype none
module date_string_check_and_day_span_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dscd_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dscd_pkg::out_word_t      out_data
);

  logic adv, in_fire;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;

  dscd_pkg::front_out_t  fo;
  dscd_pkg::check_out_t  co;
  dscd_pkg::daynum_out_t dno;

  logic                        arr_ok_r;
  logic [dscd_pkg::SPAN_W-1:0] arr_dn_r;
  dscd_pkg::out_word_t         out_data_r, out_nxt;
  logic                        ok, sv;

  // Advance every stage unless a finished word is held at the output
  assign adv      = ~out_valid_r | out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid & adv;

  dscd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_fire (in_fire),
    .in_data (in_data),
    .fo      (fo)
  );

  dscd_check u_check (
    .clk (clk),
    .adv (adv),
    .fi  (fo),
    .co  (co)
  );

  dscd_daynum u_daynum (
    .clk (clk),
    .adv (adv),
    .ci  (co),
    .dno (dno)
  );

  // Only string ends travel down the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_fire & in_data.end_of_string;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  // Span against the latest arrival; arrival always leaves this stage first
  always_comb begin
    ok = (dno.status == dscd_pkg::ST_OK);
    sv = dno.dep & arr_ok_r & ok;
    out_nxt.date_status  = 3'(dno.status);
    out_nxt.is_departure = dno.dep;
    out_nxt.span_valid   = sv;
    out_nxt.span_days    = (sv && (dno.dn > arr_dn_r)) ? dno.dn - arr_dn_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arr_ok_r <= 1'b0;
      arr_dn_r <= '0;
    end else if (adv && s4_v_r && !dno.dep) begin
      // latch the arrival date for the next departure
      arr_ok_r <= ok;
      arr_dn_r <= dno.dn;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/dscd_front.sv -----
`default_nettype none
module dscd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_fire,
  input  wire dscd_pkg::in_word_t    in_data,
  output dscd_pkg::front_out_t       fo
);

  logic [3:0]        pos_r, pos_nxt, pos_inc;
  logic              fmt_bad_r, fmt_nxt;
  logic              second_r;
  dscd_pkg::digits_t dig_r, dig_nxt;
  logic [2:0]        slot;
  logic              digit_pos, is_num;
  dscd_pkg::front_out_t fo_r;

  always_comb begin
    digit_pos = (pos_r < 4'(dscd_pkg::DATE_LEN)) && (pos_r != 4'(dscd_pkg::SEP_POS_A))
             && (pos_r != 4'(dscd_pkg::SEP_POS_B));
    is_num    = (in_data.char_code >= dscd_pkg::ASCII_ZERO)
             && (in_data.char_code <= dscd_pkg::ASCII_NINE);
    if (pos_r < 4'(dscd_pkg::SEP_POS_A)) begin
      slot = pos_r[2:0];
    end else if (pos_r < 4'(dscd_pkg::SEP_POS_B)) begin
      slot = 3'(pos_r - 4'd1);
    end else begin
      slot = 3'(pos_r - 4'd2);
    end
    pos_inc = (pos_r < 4'(dscd_pkg::POS_SAT)) ? pos_r + 4'd1 : 4'(dscd_pkg::POS_SAT);
    dig_nxt = dig_r;
    if (digit_pos) begin
      dig_nxt[slot] = is_num ? in_data.char_code[3:0] : 4'd0;
    end
    fmt_nxt = fmt_bad_r | (digit_pos & ~is_num);
    pos_nxt = pos_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fmt_bad_r <= 1'b0;
      dig_r     <= '0;
      second_r  <= 1'b0;
    end else if (in_fire) begin
      if (in_data.end_of_string) begin
        // clear for the other string
        pos_r     <= '0;
        fmt_bad_r <= 1'b0;
        dig_r     <= '0;
        second_r  <= ~second_r;
      end else begin
        pos_r     <= pos_nxt;
        fmt_bad_r <= fmt_nxt;
        dig_r     <= dig_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fo_r.fmt_err <= (pos_nxt != 4'(dscd_pkg::DATE_LEN)) | fmt_nxt;
      fo_r.dep     <= second_r;
      fo_r.dig     <= dig_nxt;
    end
  end

  assign fo = fo_r;

endmodule
`default_nettype wire

// ----- sv/dscd_check.sv -----
`default_nettype none
module dscd_check (
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire dscd_pkg::front_out_t fi,
  output dscd_pkg::check_out_t      co
);

  logic [6:0]  d, m, cc, yy;
  logic [13:0] y;
  logic        leap, early;
  dscd_pkg::status_t status;
  dscd_pkg::check_out_t co_nxt, co_r;

  always_comb begin
    d  = 7'(fi.dig[0]) * 7'd10 + 7'(fi.dig[1]);
    m  = 7'(fi.dig[2]) * 7'd10 + 7'(fi.dig[3]);
    cc = 7'(fi.dig[4]) * 7'd10 + 7'(fi.dig[5]);
    yy = 7'(fi.dig[6]) * 7'd10 + 7'(fi.dig[7]);
    y  = 14'(cc) * 14'd100 + 14'(yy);
    // divisible by 4 and not by 100, or by 400
    leap = ((yy[1:0] == 2'd0) && (yy != 7'd0)) || ((yy == 7'd0) && (cc[1:0] == 2'd0));

    priority if (fi.fmt_err) begin
      status = dscd_pkg::ST_FORMAT;
    end else if ((d == 7'd0) || (d > 7'(dscd_pkg::month_len(m, leap)))) begin
      status = dscd_pkg::ST_DAY;
    end else if ((m == 7'd0) || (m > 7'(dscd_pkg::MONTHS))) begin
      status = dscd_pkg::ST_MONTH;
    end else if (y == 14'd0) begin
      status = dscd_pkg::ST_YEAR;
    end else begin
      status = dscd_pkg::ST_OK;
    end

    // January and February count with the previous year
    early = (m <= 7'd2);
    co_nxt.status = status;
    co_nxt.dep    = fi.dep;
    co_nxt.ys     = early ? y - 14'd1 : y;
    co_nxt.cent   = (early && (yy == 7'd0)) ? cc - 7'd1 : cc;
    co_nxt.mp     = early ? m[3:0] + 4'd9 : m[3:0] - 4'd3;
    co_nxt.day    = d[4:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      co_r <= co_nxt;
    end
  end

  assign co = co_r;

endmodule
`default_nettype wire

// ----- sv/dscd_daynum.sv -----
`default_nettype none
module dscd_daynum (
  input  wire logic                 clk,
  input  wire logic                 adv,
  input  wire dscd_pkg::check_out_t ci,
  output dscd_pkg::daynum_out_t     dno
);

  logic [dscd_pkg::SPAN_W-1:0] yr_days_r;
  logic [dscd_pkg::PART_W-1:0] part_r, part_nxt;
  dscd_pkg::status_t           status_r;
  logic                        dep_r;
  dscd_pkg::daynum_out_t       dno_r;

  // Leap days plus offsets inside the year; small, wraps only for bad dates
  always_comb begin
    part_nxt = dscd_pkg::PART_W'(ci.ys >> 2) - dscd_pkg::PART_W'(ci.cent)
             + dscd_pkg::PART_W'(ci.cent >> 2)
             + dscd_pkg::PART_W'(dscd_pkg::month_offset(ci.mp))
             + dscd_pkg::PART_W'(ci.day) - dscd_pkg::PART_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yr_days_r <= dscd_pkg::SPAN_W'(ci.ys) * dscd_pkg::SPAN_W'(dscd_pkg::DAYS_PER_YEAR);
      part_r    <= part_nxt;
      status_r  <= ci.status;
      dep_r     <= ci.dep;
      dno_r.status <= status_r;
      dno_r.dep    <= dep_r;
      dno_r.dn     <= (status_r == dscd_pkg::ST_OK)
                    ? yr_days_r + dscd_pkg::SPAN_W'(part_r) : '0;
    end
  end

  assign dno = dno_r;

endmodule
`default_nettype wire

// ----- sv/dscd_checker.sv -----
`default_nettype none
module dscd_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire dscd_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dscd_pkg::out_word_t out_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_span_dep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.span_valid |-> out_data.is_departure)
    else $error("span on an arrival result");

  a_span_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.span_valid |-> out_data.span_days == '0)
    else $error("span days without a valid span");

  a_span_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.span_valid |-> out_data.date_status == 3'(dscd_pkg::ST_OK))
    else $error("span given with a bad departure date");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

endmodule

bind date_string_check_and_day_span_top dscd_checker u_dscd_checker (.*);
`default_nettype wire

// ----- dv/date_string_check_and_day_span_top_tb.sv -----
module date_string_check_and_day_span_top_tb;
  import dscd_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  date_string_check_and_day_span_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Directed strings. Text is right-aligned in the vector, so the length is
  // the count of nonzero bytes. A '~' stands for a digit with bit 7 set.
  // Rows with typed set carry a result that is known by inspection.
  typedef struct packed {
    logic [12*8-1:0]   text;
    logic              typed;
    status_t           status;
    logic              span_ok;
    logic [SPAN_W-1:0] span;
  } date_row_t;

  date_row_t date_rows [24] = '{
    '{"01/01/0001",  1'b1, ST_OK,     1'b0, 22'd0},  // earliest date
    '{"31/12/9999",  1'b0, ST_OK,     1'b0, 22'd0},  // latest date, widest span
    '{"29/02/2000",  1'b1, ST_OK,     1'b0, 22'd0},  // leap by the 400 rule
    '{"29/02/1900",  1'b1, ST_DAY,    1'b0, 22'd0},  // century, not leap
    '{"00/05/2020",  1'b1, ST_DAY,    1'b0, 22'd0},
    '{"15/13/2020",  1'b1, ST_DAY,    1'b0, 22'd0},  // bad month shows as day error
    '{"01/01/0000",  1'b1, ST_YEAR,   1'b0, 22'd0},
    '{"1/1/2020",    1'b1, ST_FORMAT, 1'b0, 22'd0},  // too short
    '{"01/01/20201", 1'b1, ST_FORMAT, 1'b0, 22'd0},  // too long
    '{"0a/01/2020",  1'b1, ST_FORMAT, 1'b0, 22'd0},
    '{"0~/01/2020",  1'b1, ST_FORMAT, 1'b0, 22'd0},  // high character
    '{"x",           1'b1, ST_FORMAT, 1'b0, 22'd0},  // single character
    '{"10.10.2010",  1'b1, ST_OK,     1'b0, 22'd0},
    '{"10-10-2010",  1'b1, ST_OK,     1'b1, 22'd0},  // same day, span zero
    '{"02/03/2021",  1'b1, ST_OK,     1'b0, 22'd0},
    '{"01/03/2021",  1'b1, ST_OK,     1'b1, 22'd0},  // earlier, saturates to zero
    '{"28/02/2024",  1'b1, ST_OK,     1'b0, 22'd0},
    '{"01/03/2024",  1'b1, ST_OK,     1'b1, 22'd2},  // across a leap day
    '{"0101012020",  1'b0, ST_OK,     1'b0, 22'd0},  // digits in separator slots
    '{"31/01/0001",  1'b0, ST_OK,     1'b0, 22'd0},
    '{"31/04/2021",  1'b1, ST_DAY,    1'b0, 22'd0},
    '{"30/04/2021",  1'b1, ST_OK,     1'b0, 22'd0},  // arrival was bad
    '{"99/99/9999",  1'b1, ST_DAY,    1'b0, 22'd0},  // all digits high
    '{"00/00/0000",  1'b1, ST_DAY,    1'b0, 22'd0}   // all digits low
  };

  // Predicted state of the block, at its reset values
  int                char_pos          = 0;
  logic              fmt_bad           = 1'b0;
  digit_t            held_digits [NUM_DIGITS] = '{default: '0};
  logic              expect_departure  = 1'b0;
  logic [SPAN_W-1:0] arrival_dn        = '0;
  logic              arrival_valid     = 1'b0;

  out_word_t   awaited_results [$];
  logic [7:0]  date_chars [$];
  logic        steady = 1'b0;   // no idling on either side while set
  int unsigned last_year = 0;
  int          fails = 0;
  int          chars_sent = 0;
  int          strings_sent = 0;
  int          results_seen = 0;
  int          spans_seen = 0;
  int          status_tally [5] = '{default: 0};

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    bit leap;
    leap = (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Day count from a fixed epoch, years starting in March
  function automatic int unsigned epoch_day(int unsigned d, int unsigned m,
                                            int unsigned y);
    int unsigned ys, mp;
    ys = (m <= 2) ? y - 1 : y;
    mp = (m + 9) % 12;
    return 365 * ys + ys / 4 - ys / 100 + ys / 400 + (153 * mp + 2) / 5 + d - 1;
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(1, 4);
      1:       return $urandom_range(9996, 9999);
      2:       return 100 * $urandom_range(1, 99);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  // Advance the predicted state by one accepted character word; on a string
  // end, hand back the result word the block must produce.
  task automatic predict_date_char(input in_word_t w, output bit done,
                                   output out_word_t r);
    int          slot;
    int unsigned dd, mm, yy, dn;
    status_t     st;
    done = 1'b0;
    r    = '0;
    if (char_pos < DATE_LEN && char_pos != SEP_POS_A && char_pos != SEP_POS_B) begin
      slot = (char_pos < SEP_POS_A) ? char_pos :
             (char_pos < SEP_POS_B) ? char_pos - 1 : char_pos - 2;
      if (w.char_code < ASCII_ZERO || w.char_code > ASCII_NINE) begin
        fmt_bad = 1'b1;
        held_digits[slot] = '0;
      end else begin
        held_digits[slot] = digit_t'(w.char_code - ASCII_ZERO);
      end
    end
    if (char_pos < POS_SAT) char_pos++;
    if (!w.end_of_string) return;

    dd = held_digits[0] * 10 + held_digits[1];
    mm = held_digits[2] * 10 + held_digits[3];
    yy = held_digits[4] * 1000 + held_digits[5] * 100 + held_digits[6] * 10
       + held_digits[7];
    if (char_pos != DATE_LEN || fmt_bad) st = ST_FORMAT;
    else if (dd == 0 || dd > days_in_month(mm, yy)) st = ST_DAY;
    else if (mm == 0 || mm > MONTHS) st = ST_MONTH;
    else if (yy == 0) st = ST_YEAR;
    else st = ST_OK;
    dn = (st == ST_OK) ? epoch_day(dd, mm, yy) : 0;

    r.date_status  = st;
    r.is_departure = expect_departure;
    if (expect_departure) begin
      if (arrival_valid && st == ST_OK) begin
        r.span_valid = 1'b1;
        r.span_days  = (dn > arrival_dn) ? SPAN_W'(dn - arrival_dn) : '0;
      end
    end else begin
      arrival_valid = (st == ST_OK);
      arrival_dn    = SPAN_W'(dn);
    end
    expect_departure = ~expect_departure;
    char_pos    = 0;
    fmt_bad     = 1'b0;
    held_digits = '{default: '0};
    done        = 1'b1;
  endtask

  // Offer one character word, hold it until taken, then predict
  task automatic push_char(input in_word_t w, output bit done, output out_word_t r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    chars_sent++;
    predict_date_char(w, done, r);
  endtask

  // Send the string held in date_chars; a typed row replaces the predicted
  // status and span with its own values.
  task automatic send_date_chars(input bit typed, input status_t st, input logic sv,
                                 input logic [SPAN_W-1:0] sd);
    in_word_t  w;
    bit        done;
    out_word_t r;
    foreach (date_chars[i]) begin
      w.char_code     = date_chars[i];
      w.end_of_string = (i == date_chars.size() - 1);
      push_char(w, done, r);
      if (done) begin
        if (typed) begin
          r.date_status = st;
          r.span_valid  = sv;
          r.span_days   = sd;
        end
        awaited_results.push_back(r);
        strings_sent++;
      end
    end
  endtask

  // Build one random string: mostly well-formed dates with random separators,
  // then dates with a bad field, a corrupted digit, a wrong length, or noise.
  task automatic build_random_date();
    int unsigned dd, mm, yy, kind, n, slot;
    logic [7:0]  b;
    date_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      n = $urandom_range(1, 14);
      repeat (n) date_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    // keep some departures in the arrival's year so spans stay small
    if (expect_departure && last_year != 0 && $urandom_range(0, 2) == 0)
      yy = last_year;
    else
      yy = pick_year();
    if (!expect_departure) last_year = yy;
    mm = $urandom_range(1, MONTHS);
    dd = $urandom_range(1, days_in_month(mm, yy));
    if (kind >= 55 && kind < 70) begin
      case ($urandom_range(0, 4))
        0:       dd = 0;
        1:       dd = $urandom_range(days_in_month(mm, yy) + 1, 99);
        2:       mm = 0;
        3:       mm = $urandom_range(MONTHS + 1, 99);
        default: yy = 0;
      endcase
    end
    date_chars.push_back(ASCII_ZERO + 8'(dd / 10));
    date_chars.push_back(ASCII_ZERO + 8'(dd % 10));
    date_chars.push_back(8'($urandom_range(0, 255)));
    date_chars.push_back(ASCII_ZERO + 8'(mm / 10));
    date_chars.push_back(ASCII_ZERO + 8'(mm % 10));
    date_chars.push_back(8'($urandom_range(0, 255)));
    date_chars.push_back(ASCII_ZERO + 8'(yy / 1000));
    date_chars.push_back(ASCII_ZERO + 8'(yy / 100 % 10));
    date_chars.push_back(ASCII_ZERO + 8'(yy / 10 % 10));
    date_chars.push_back(ASCII_ZERO + 8'(yy % 10));
    if (kind >= 70 && kind < 82) begin
      // drop a non-digit into one digit slot
      slot = $urandom_range(0, NUM_DIGITS - 1);
      b = 8'($urandom_range(0, 245));
      if (b >= ASCII_ZERO) b += 8'd10;
      date_chars[slot + (slot >= 2) + (slot >= 4)] = b;
    end else if (kind >= 82) begin
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(1, DATE_LEN - 1);
        while (date_chars.size() > n) void'(date_chars.pop_back());
      end else begin
        n = $urandom_range(DATE_LEN + 1, 14);
        while (date_chars.size() < n) date_chars.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result side: stall out_ready at random and check every word taken
  initial begin : result_sink
    out_word_t want;
    int        hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result word: status %0d dep %0d span_valid %0d span %0d",
                     out_data.date_status, out_data.is_departure,
                     out_data.span_valid, out_data.span_days);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.date_status !== want.date_status ||
              out_data.is_departure !== want.is_departure ||
              out_data.span_valid !== want.span_valid ||
              out_data.span_days !== want.span_days) begin
            fails++;
            if (fails <= 10)
              $display("result %0d: expected status %0d dep %0d span_valid %0d span %0d,%s",
                       results_seen, want.date_status, want.is_departure,
                       want.span_valid, want.span_days, "");
            if (fails <= 10)
              $display("  got status %0d dep %0d span_valid %0d span %0d",
                       out_data.date_status, out_data.is_departure,
                       out_data.span_valid, out_data.span_days);
          end
          if (want.date_status <= ST_YEAR) status_tally[want.date_status]++;
          if (want.span_valid) spans_seen++;
        end
      end
      // advance the stall pattern; keep ready high in steady stretches
      if (hold > 0) begin
        hold--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        hold = idle_len();
      end
    end
  end

  initial begin : stimulus
    int          len;
    int          base;
    int          waited;
    date_row_t   row;
    logic [7:0]  c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings, walked in order
    foreach (date_rows[k]) begin
      row = date_rows[k];
      len = 0;
      for (int b = 0; b < 12; b++) if (row.text[8*b +: 8] != 8'h00) len = b + 1;
      date_chars.delete();
      for (int i = 0; i < len; i++) begin
        c = row.text[8*(len-1-i) +: 8];
        if (c == "~") c = ASCII_ZERO | 8'h80;
        date_chars.push_back(c);
      end
      send_date_chars(row.typed, row.status, row.span_ok, row.span);
    end

    // Random strings; flip in and out of steady stretches now and then
    base = chars_sent;
    while (chars_sent - base < 770) begin
      if ($urandom_range(0, 24) == 0) steady = ~steady;
      build_random_date();
      send_date_chars(1'b0, ST_OK, 1'b0, '0);
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    // Drain: wait for every result word, then let the pipeline empty
    waited = 0;
    while (awaited_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0d result words never arrived", awaited_results.size());
      fails += awaited_results.size();
    end

    $display("drove %0d date strings in %0d character words; checked %0d results",
             strings_sent, chars_sent, results_seen);
    $display("status ok/format/day/month/year: %0d/%0d/%0d/%0d/%0d; %0d carried a span",
             status_tally[ST_OK], status_tally[ST_FORMAT], status_tally[ST_DAY],
             status_tally[ST_MONTH], status_tally[ST_YEAR], spans_seen);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dscd_pkg.sv
sv/dscd_front.sv
sv/dscd_check.sv
sv/dscd_daynum.sv
sv/date_string_check_and_day_span_top.sv
sv/dscd_checker.sv
dv/date_string_check_and_day_span_top_tb.sv
